// ===== hdl/bslg_pkg.sv =====
// Shared types, constants and helpers for the barrel sector mapper.
// Used by bslg_cordic and barrel_sector_local_to_global; no dependencies.
package bslg_pkg;

	localparam int MAX_LAYERS   = 64;
	localparam int LAYER_AW     = $clog2(MAX_LAYERS);
	localparam int CORDIC_STEPS = 24;
	localparam int GUARD        = 16;
	localparam int CW           = 52;   // CORDIC datapath width
	localparam logic [31:0] GAIN_Q32  = 32'd2608131496;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] QUARTER   = 32'h4000_0000;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_TRACK = 2'd1;
	localparam logic [1:0] KIND_POINT = 2'd2;

	localparam logic CFG_SECTORS = 1'b0;
	localparam logic CFG_LAYERS  = 1'b1;

	typedef struct packed {
		logic start;
		logic rot_mode;
	} cordic_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_sts_t;

	function automatic logic [31:0] atan(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sh00_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -40'sh00_8000_0000)
			r = -32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== hdl/bslg_cordic.sv =====
// Iterative CORDIC unit: vectoring (angle) or rotation with gain removal.
// One micro-rotation per cycle, then, in rotation mode only, gain removal on a shared 27x32 multiplier.
// Depends on bslg_pkg.
module bslg_cordic (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bslg_pkg::cordic_ctl_t     ctl,
	input  logic signed [32:0]        x_in,
	input  logic signed [32:0]        y_in,
	input  logic [31:0]               ang_in,
	output bslg_pkg::cordic_sts_t     sts,
	output logic [31:0]               ang_out,
	output logic signed [31:0]        x_out,
	output logic signed [31:0]        y_out
);

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_ITER = 2'd1;
	localparam logic [1:0] C_GAIN = 2'd2;

	logic [1:0]                      cst_q;
	logic [4:0]                      i_q;
	logic [1:0]                      g_q;
	logic                            mode_q, zero_q, done_q;
	logic signed [bslg_pkg::CW-1:0]  x_q, y_q;
	logic signed [33:0]              z_q;
	logic [31:0]                     ang_q;
	logic [58:0]                     p_q;

	logic signed [bslg_pkg::CW-1:0]  xs, ys, dx, dy, coord, mag;
	logic [31:0]                     at, a_wrap, a_rot;
	logic [26:0]                     op;
	logic [58:0]                     prod;
	logic [59:0]                     gsum;
	logic signed [bslg_pkg::CW-1:0]  gres;
	logic signed [52:0]              xr, yr;

	always_comb begin
		xs = {{3{x_in[32]}}, x_in, 16'b0};
		ys = {{3{y_in[32]}}, y_in, 16'b0};
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = bslg_pkg::atan(i_q);
		a_wrap = ang_in + bslg_pkg::QUARTER;
		a_rot = a_wrap[31] ? ang_in - bslg_pkg::HALF_TURN : ang_in;
		coord = g_q[1] ? y_q : x_q;
		mag = coord[bslg_pkg::CW-1] ? -coord : coord;
		op = g_q[0] ? mag[bslg_pkg::CW-1:25] : {2'b0, mag[24:0]};
		prod = 59'(op) * 59'(bslg_pkg::GAIN_Q32);
		gsum = 60'(prod) + 60'(p_q >> 25);
		gres = coord[bslg_pkg::CW-1] ? -gsum[bslg_pkg::CW+6:7] : gsum[bslg_pkg::CW+6:7];
		xr = (53'(x_q) + 53'sd32768) >>> bslg_pkg::GUARD;
		yr = (53'(y_q) + 53'sd32768) >>> bslg_pkg::GUARD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q  <= C_IDLE;
			done_q <= 1'b0;
			i_q    <= '0;
			g_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (cst_q)
				C_IDLE: begin
					if (ctl.start) begin
						cst_q <= C_ITER;
						i_q <= '0;
						g_q <= '0;
					end
				end
				C_ITER: begin
					if (i_q == 5'(bslg_pkg::CORDIC_STEPS - 1)) begin
						if (mode_q)
							cst_q <= C_GAIN;
						else begin
							cst_q <= C_IDLE;
							done_q <= 1'b1;
						end
					end
					i_q <= i_q + 5'd1;
				end
				C_GAIN: begin
					g_q <= g_q + 2'd1;
					if (g_q == 2'd3) begin
						cst_q <= C_IDLE;
						done_q <= 1'b1;
					end
				end
				default: cst_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cst_q == C_IDLE && ctl.start) begin
			mode_q <= ctl.rot_mode;
			zero_q <= (x_in == 33'sd0) && (y_in == 33'sd0);
			if (ctl.rot_mode) begin
				x_q <= a_wrap[31] ? -xs : xs;
				y_q <= a_wrap[31] ? -ys : ys;
				z_q <= {{2{a_rot[31]}}, a_rot};
			end else begin
				x_q <= x_in[32] ? -xs : xs;
				y_q <= x_in[32] ? -ys : ys;
				ang_q <= x_in[32] ? bslg_pkg::HALF_TURN : 32'd0;
			end
		end else if (cst_q == C_ITER) begin
			if (mode_q) begin
				if (!z_q[33]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - {2'b0, at};
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + {2'b0, at};
				end
			end else begin
				if (!y_q[bslg_pkg::CW-1]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					ang_q <= ang_q + at;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					ang_q <= ang_q - at;
				end
			end
		end else if (cst_q == C_GAIN) begin
			if (!g_q[0])
				p_q <= prod;
			else if (g_q[1])
				y_q <= gres;
			else
				x_q <= gres;
		end
	end

	assign sts.busy = (cst_q != C_IDLE);
	assign sts.done = done_q;
	assign ang_out = zero_q ? 32'd0 : ang_q;
	assign x_out = bslg_pkg::sat32(40'(xr));
	assign y_out = bslg_pkg::sat32(40'(yr));

endmodule

// ===== hdl/barrel_sector_local_to_global.sv =====
// Top level: barrel sector local-to-global mapper with layer table and sequencer.
// Depends on bslg_pkg and bslg_cordic.
//
// channel  direction  handshake          payload
// s_       in         s_tvalid/s_tready  s_tuser kind, s_tdata fields
// m_       out        m_tvalid/m_tready  m_tdata result fields
// cfg_     in         cfg_we             cfg_index, cfg_data
//
// Load, unused kind or dropped point: accepted, then straight to output. Track: vectoring,
// sector bin, divide, rotate, layer search, output.
// Point: divide, table read, rotate, output.
// CORDIC steps use the single CORDIC unit; divides use the bit-serial sector-angle divider.
// Reset clears control state; s_tready is high only when idle, and a result
// holds in m_tdata until taken.
module barrel_sector_local_to_global (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [1:0]    s_tuser,    // kind
	input  logic [199:0]  s_tdata,    // layer_index, depth_value, track_x, track_y,
	                                  // track_z, local_x, local_y, zero pad
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [119:0]  m_tdata,    // sector, first_layer, layers_used, global_x,
	                                  // global_y, global_z, dropped, zero pad
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [6:0]    cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_VEC  = 4'd1;
	localparam logic [3:0] S_BIN  = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_RD   = 4'd4;
	localparam logic [3:0] S_ROT  = 4'd5;
	localparam logic [3:0] S_SRD  = 4'd6;
	localparam logic [3:0] S_SCMP = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	localparam int AW = bslg_pkg::LAYER_AW;

	logic [3:0]  state_q;
	logic [4:0]  sector_count_q;
	logic [6:0]  layer_count_q;
	logic [1:0]  kind_q;
	logic signed [31:0] trk_x_q, trk_y_q, trk_z_q;
	logic signed [31:0] xr_q, roty_q, rotz_q;
	logic [3:0]  cur_sector_q;
	logic [AW-1:0] first_q, l_q, d_q;
	logic [6:0]  used_q;
	logic signed [32:0] py_q;
	logic signed [31:0] gx_q, gy_q, gz_q;
	logic        drop_q;
	logic [35:0] div_q;
	logic [4:0]  rem_q;
	logic [5:0]  dcnt_q;
	logic [31:0] ang_q;
	logic        start_q, rot_mode_q;

	logic signed [31:0] mem [bslg_pkg::MAX_LAYERS];
	logic signed [31:0] rd_q;
	logic [AW-1:0] rd_addr;

	logic        acc;
	logic [1:0]  in_kind;
	logic [5:0]  in_idx;
	logic signed [31:0] in_depth, in_tx, in_ty, in_tz, in_lx, in_ly;
	logic [4:0]  n;
	logic [6:0]  cnt;
	logic [6:0]  n2;
	logic [6:0]  pd;
	logic [37:0] bprod;
	logic [5:0]  bin;
	logic [3:0]  sec;
	logic [5:0]  r2;
	logic        qbit;
	logic [35:0] div_next;
	logic        pt_ok;

	bslg_pkg::cordic_ctl_t c_ctl;
	bslg_pkg::cordic_sts_t c_sts;
	logic signed [32:0] c_x, c_y;
	logic [31:0] c_ang;
	logic signed [31:0] c_xo, c_yo;

	assign in_kind  = s_tuser;
	assign in_idx   = s_tdata[5:0];
	assign in_depth = s_tdata[37:6];
	assign in_tx    = s_tdata[69:38];
	assign in_ty    = s_tdata[101:70];
	assign in_tz    = s_tdata[133:102];
	assign in_lx    = s_tdata[165:134];
	assign in_ly    = s_tdata[197:166];

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign acc = s_tvalid && s_tready;

	always_comb begin
		if (sector_count_q < 5'd3)
			n = 5'd3;
		else if (sector_count_q > 5'd16)
			n = 5'd16;
		else
			n = sector_count_q;
		if (layer_count_q == 7'd0)
			cnt = 7'd1;
		else if (layer_count_q > 7'(bslg_pkg::MAX_LAYERS))
			cnt = 7'(bslg_pkg::MAX_LAYERS);
		else
			cnt = layer_count_q;
		n2 = {1'b0, n, 1'b0};
		pd = 7'(in_idx) + 7'(first_q);
		pt_ok = (in_kind == bslg_pkg::KIND_POINT) && ({1'b0, in_idx} < used_q) && !pd[6];
		bprod = 38'(c_ang) * 38'(n2);
		bin = bprod[37:32];
		sec = ({1'b0, bin} == 7'd0 || {1'b0, bin} == n2 - 7'd1) ? 4'd0 :
		      4'(({1'b0, bin} + 7'd1) >> 1);
		r2 = {rem_q, div_q[35]};
		qbit = (r2 >= {1'b0, n});
		div_next = {div_q[34:0], qbit};
		rd_addr = (state_q == S_SRD) ? l_q : d_q;
		c_ctl.start = start_q;
		c_ctl.rot_mode = rot_mode_q;
		c_x = (kind_q == bslg_pkg::KIND_POINT) ? 33'(rd_q) : 33'(trk_x_q);
		c_y = (kind_q == bslg_pkg::KIND_POINT) ? py_q : 33'(trk_y_q);
	end

	bslg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (c_ctl),
		.x_in    (c_x),
		.y_in    (c_y),
		.ang_in  (ang_q),
		.sts     (c_sts),
		.ang_out (c_ang),
		.x_out   (c_xo),
		.y_out   (c_yo)
	);

	always_ff @(posedge clk) begin
		if (acc && in_kind == bslg_pkg::KIND_LOAD)
			mem[in_idx[AW-1:0]] <= in_depth;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			sector_count_q <= 5'd8;
			layer_count_q  <= 7'd64;
			roty_q         <= '0;
			rotz_q         <= '0;
			cur_sector_q   <= '0;
			first_q        <= '0;
			used_q         <= '0;
			start_q        <= 1'b0;
			rot_mode_q     <= 1'b0;
			kind_q         <= '0;
			dcnt_q         <= '0;
			l_q            <= '0;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == bslg_pkg::CFG_SECTORS)
					sector_count_q <= cfg_data[4:0];
				else
					layer_count_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						kind_q <= in_kind;
						if (in_kind == bslg_pkg::KIND_TRACK) begin
							start_q <= 1'b1;
							rot_mode_q <= 1'b0;
							state_q <= S_VEC;
						end else if (pt_ok) begin
							dcnt_q <= '0;
							state_q <= S_DIV;
						end else
							state_q <= S_OUT;
					end
				end
				S_VEC: begin
					if (c_sts.done)
						state_q <= S_BIN;
				end
				S_BIN: begin
					cur_sector_q <= sec;
					dcnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd35) begin
						if (kind_q == bslg_pkg::KIND_TRACK) begin
							start_q <= 1'b1;
							rot_mode_q <= 1'b1;
							state_q <= S_ROT;
						end else
							state_q <= S_RD;
					end
				end
				S_RD: begin
					start_q <= 1'b1;
					rot_mode_q <= 1'b1;
					state_q <= S_ROT;
				end
				S_ROT: begin
					if (c_sts.done) begin
						if (kind_q == bslg_pkg::KIND_TRACK) begin
							roty_q <= c_yo;
							rotz_q <= trk_z_q;
							l_q <= '0;
							state_q <= S_SRD;
						end else
							state_q <= S_OUT;
					end
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					if (rd_q > xr_q || 7'(l_q) == cnt - 7'd1) begin
						first_q <= l_q;
						used_q <= cnt - 7'(l_q);
						state_q <= S_OUT;
					end else begin
						l_q <= l_q + AW'(1);
						state_q <= S_SRD;
					end
				end
				S_OUT: begin
					if (m_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			trk_x_q <= in_tx;
			trk_y_q <= in_ty;
			trk_z_q <= in_tz;
			d_q <= pd[AW-1:0];
			py_q <= 33'(roty_q) + 33'(in_ly);
			gx_q <= '0;
			gy_q <= '0;
			gz_q <= pt_ok ? bslg_pkg::sat32(40'(rotz_q) - 40'(in_lx)) : 32'sd0;
			drop_q <= (in_kind == bslg_pkg::KIND_POINT) &&
			          ({1'b0, in_idx} >= used_q || pd[6]);
			if (in_kind == bslg_pkg::KIND_POINT) begin
				div_q <= {cur_sector_q, 32'd0} + 36'(n >> 1);
				rem_q <= '0;
			end
		end
		if (state_q == S_BIN) begin
			div_q <= {sec, 32'd0} + 36'(n >> 1);
			rem_q <= '0;
		end
		if (state_q == S_DIV) begin
			div_q <= div_next;
			rem_q <= qbit ? 5'(r2 - {1'b0, n}) : r2[4:0];
			if (dcnt_q == 6'd35)
				ang_q <= (kind_q == bslg_pkg::KIND_TRACK) ? 32'd0 - div_next[31:0]
				                                         : div_next[31:0];
		end
		if (state_q == S_ROT && c_sts.done) begin
			if (kind_q == bslg_pkg::KIND_TRACK)
				xr_q <= c_xo;
			else begin
				gx_q <= c_xo;
				gy_q <= c_yo;
			end
		end
	end

	assign m_tdata = {6'd0, drop_q, gz_q, gy_q, gx_q, used_q, first_q, cur_sector_q};

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("ready while result pending");
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && drop_q) |-> (gx_q == 32'sd0 && gy_q == 32'sd0 && gz_q == 32'sd0))
		else $error("dropped point carries coordinates");
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCMP) |-> (7'(l_q) < cnt)) else $error("layer search overrun");
	a_cordic_idle: assert property (@(posedge clk) disable iff (!arst_n)
		c_sts.busy |-> (state_q == S_VEC || state_q == S_ROT))
		else $error("CORDIC busy outside its states");

endmodule
